### rtl/lcs_pkg.sv
// shared types and constants for the lane center steering block
// request and response words of the shared divider; no dependencies
package lcs_pkg;

  localparam int DIVIDEND_W = 23;
  localparam int DIVISOR_W  = 8;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/lcs_if.sv
// valid/ready channel interfaces for pixel words and result words
// no dependencies
interface lcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic [6:0] col;
  logic [5:0] row;
  logic       end_of_frame;

  modport source (output valid, pixel, col, row, end_of_frame, input ready);
  modport sink   (input valid, pixel, col, row, end_of_frame, output ready);
endinterface

interface lcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steering;
  logic [14:0]        throttle;
  logic [6:0]         lower_mid;
  logic [6:0]         upper_mid;

  modport source (output valid, steering, throttle, lower_mid, upper_mid, input ready);
  modport sink   (input valid, steering, throttle, lower_mid, upper_mid, output ready);
endinterface

### rtl/lcs_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on lcs_pkg for the request and response words
module lcs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lcs_pkg::div_req_t req,
  output lcs_pkg::div_rsp_t rsp
);
  import lcs_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  dsr_r;

  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    ge      = trial >= {1'b0, dsr_r};
    diff    = trial - {1'b0, dsr_r};
    // for a nonzero divisor the remainder stays below it, so it fits the divisor width
    rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### rtl/lane_center_steering.sv
// lane center steering: non-final pixel words are taken back to back while idle;
// the end-of-frame word runs the shared divider three times (lower mid, upper mid,
// steering, with a gain multiply step before the last), so its result becomes valid
// after the steering division and pixel input resumes then, later while the
// previous result word is still held
// synchronous active-low reset loads register defaults and clears all counters
module lane_center_steering #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lcs_in_if.sink      in_if,
  lcs_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lcs_pkg::*;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_STEER_GAIN   = 3'd2;
  localparam logic [2:0] REG_LOST_LIMIT   = 3'd3;
  localparam logic [2:0] REG_CRUISE       = 3'd4;
  localparam logic [2:0] REG_SEARCH_STEER = 3'd5;

  localparam int         W_CLIP   = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
  localparam int         H_CLIP   = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
  localparam logic [7:0] W_CLIP_V = 8'(W_CLIP);
  localparam logic [6:0] H_CLIP_V = 7'(H_CLIP);

  typedef enum logic [2:0] {S_IDLE, S_LO, S_UP, S_MUL, S_ST, S_OUT} state_t;

  // configuration registers
  logic [7:0]  image_width_r;
  logic [6:0]  image_height_r;
  logic [7:0]  steer_gain_r;
  logic [9:0]  lost_limit_r;
  logic [14:0] cruise_r;
  logic [6:0]  search_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 8'd80;
      image_height_r <= 7'd20;
      steer_gain_r   <= 8'd50;
      lost_limit_r   <= 10'd500;
      cruise_r       <= 15'd3000;
      search_r       <= 7'd40;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_IMAGE_WIDTH:  image_width_r  <= pwdata[7:0];
        REG_IMAGE_HEIGHT: image_height_r <= pwdata[6:0];
        REG_STEER_GAIN:   steer_gain_r   <= pwdata[7:0];
        REG_LOST_LIMIT:   lost_limit_r   <= pwdata[9:0];
        REG_CRUISE:       cruise_r       <= pwdata[14:0];
        REG_SEARCH_STEER: search_r       <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_IMAGE_WIDTH:  prdata = {24'd0, image_width_r};
      REG_IMAGE_HEIGHT: prdata = {25'd0, image_height_r};
      REG_STEER_GAIN:   prdata = {24'd0, steer_gain_r};
      REG_LOST_LIMIT:   prdata = {22'd0, lost_limit_r};
      REG_CRUISE:       prdata = {17'd0, cruise_r};
      REG_SEARCH_STEER: prdata = {25'd0, search_r};
      default:          prdata = 32'd0;
    endcase
  end

  // sequencer state
  state_t             state_r;
  logic [13:0]        lo_sum_r, up_sum_r;
  logic [7:0]         lo_cnt_r, up_cnt_r;
  logic               last_pos_r;
  logic [9:0]         lost_r;
  logic [6:0]         lower_mid_r, upper_mid_r;
  logic [15:0]        prod_r;
  logic               neg_r;
  logic               start_r;
  logic signed [15:0] res_steer_r;
  logic [14:0]        res_thr_r;
  logic               out_valid_r;
  logic signed [15:0] out_steer_r;
  logic [14:0]        out_thr_r;
  logic [6:0]         out_lower_r, out_upper_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  lcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // frame geometry
  logic [7:0] eff_w;
  logic [6:0] eff_h;
  logic [8:0] h3;
  logic [6:0] lower_row, upper_row;
  logic       edge_hit, hit_lo, hit_up;
  logic [14:0] lo_add, up_add;

  always_comb begin
    eff_w     = (image_width_r > W_CLIP_V) ? W_CLIP_V : image_width_r;
    eff_h     = (image_height_r > H_CLIP_V) ? H_CLIP_V : image_height_r;
    h3        = {2'b0, eff_h} + {1'b0, eff_h, 1'b0};
    lower_row = h3[8:2];
    upper_row = {2'b0, eff_h[6:2]};
    edge_hit  = (in_if.pixel != 8'd0) && ({1'b0, in_if.col} < eff_w);
    hit_lo    = edge_hit && ({1'b0, in_if.row} == lower_row);
    hit_up    = edge_hit && ({1'b0, in_if.row} == upper_row);
    lo_add    = {1'b0, lo_sum_r} + {8'd0, in_if.col};
    up_add    = {1'b0, up_sum_r} + {8'd0, in_if.col};
  end

  // divider operands follow the phase that issues the start
  always_comb begin
    div_req.start = start_r;
    unique case (state_r)
      S_LO: begin
        div_req.dividend = {9'd0, lo_sum_r};
        div_req.divisor  = lo_cnt_r;
      end
      S_UP: begin
        div_req.dividend = {9'd0, up_sum_r};
        div_req.divisor  = up_cnt_r;
      end
      default: begin
        div_req.dividend = {prod_r, 7'd0};
        div_req.divisor  = eff_w;
      end
    endcase
  end

  // lane offset 2*lower - width as magnitude and sign
  logic signed [9:0] offs;
  logic [9:0]        offs_mag;
  logic [6:0]        quo_mid;
  always_comb begin
    offs     = $signed({2'b0, lower_mid_r, 1'b0}) - $signed({2'b0, eff_w});
    offs_mag = offs[9] ? 10'(-offs) : 10'(offs);
    quo_mid  = (div_rsp.quotient > 23'd127) ? 7'd127 : div_rsp.quotient[6:0];
  end

  // final decision once the steering quotient is in
  logic signed [15:0] prop;
  logic signed [15:0] search_val;
  logic [10:0]        lost_inc;
  logic [10:0]        lost_hold;
  logic signed [15:0] dec_steer;
  logic [14:0]        dec_thr;
  logic [9:0]         dec_lost;
  always_comb begin
    if (eff_w == 8'd0) begin
      prop = 16'sd0;
    end else if (neg_r) begin
      prop = (div_rsp.quotient >= 23'd32768) ? -16'sd32768
           : $signed(16'(~{1'b0, div_rsp.quotient[14:0]} + 16'd1));
    end else begin
      prop = (div_rsp.quotient > 23'd32767) ? 16'sd32767
           : $signed({1'b0, div_rsp.quotient[14:0]});
    end
    search_val = last_pos_r ? $signed({1'b0, search_r, 8'd0})
                            : $signed(16'(~{1'b0, search_r, 8'd0} + 16'd1));
    lost_inc  = {1'b0, lost_r} + 11'd1;
    lost_hold = {1'b0, lost_limit_r} + 11'd1;
    if (lower_mid_r != 7'd0) begin
      dec_steer = prop;
      dec_thr   = cruise_r;
      dec_lost  = 10'd0;
    end else if (lost_inc > {1'b0, lost_limit_r}) begin
      dec_steer = prop;
      dec_thr   = 15'd0;
      dec_lost  = lost_hold[10] ? 10'h3ff : lost_hold[9:0];
    end else begin
      dec_steer = search_val;
      dec_thr   = cruise_r;
      dec_lost  = lost_inc[9:0];
    end
  end

  logic in_acc, out_free;
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lo_sum_r    <= '0;
      lo_cnt_r    <= '0;
      up_sum_r    <= '0;
      up_cnt_r    <= '0;
      last_pos_r  <= 1'b0;
      lost_r      <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (hit_lo) begin
              lo_sum_r <= lo_add[14] ? 14'h3fff : lo_add[13:0];
              lo_cnt_r <= (lo_cnt_r == 8'hff) ? lo_cnt_r : lo_cnt_r + 8'd1;
            end
            if (hit_up) begin
              up_sum_r <= up_add[14] ? 14'h3fff : up_add[13:0];
              up_cnt_r <= (up_cnt_r == 8'hff) ? up_cnt_r : up_cnt_r + 8'd1;
            end
            if (in_if.end_of_frame) begin
              start_r <= 1'b1;
              state_r <= S_LO;
            end
          end
        end
        S_LO: begin
          if (div_rsp.done) begin
            lower_mid_r <= (lo_sum_r == 14'd0 || lo_cnt_r == 8'd0) ? 7'd0 : quo_mid;
            start_r     <= 1'b1;
            state_r     <= S_UP;
          end
        end
        S_UP: begin
          if (div_rsp.done) begin
            upper_mid_r <= (up_sum_r == 14'd0 || up_cnt_r == 8'd0) ? 7'd0 : quo_mid;
            state_r     <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= offs_mag[7:0] * steer_gain_r;
          neg_r   <= offs[9];
          start_r <= 1'b1;
          state_r <= S_ST;
        end
        S_ST: begin
          if (div_rsp.done) begin
            res_steer_r <= dec_steer;
            res_thr_r   <= dec_thr;
            lost_r      <= dec_lost;
            if (lower_mid_r != 7'd0 && upper_mid_r != 7'd0) begin
              last_pos_r <= upper_mid_r > lower_mid_r;
            end
            lo_sum_r <= '0;
            lo_cnt_r <= '0;
            up_sum_r <= '0;
            up_cnt_r <= '0;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_steer_r <= res_steer_r;
            out_thr_r   <= res_thr_r;
            out_lower_r <= lower_mid_r;
            out_upper_r <= upper_mid_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.steering  = out_steer_r;
  assign out_if.throttle  = out_thr_r;
  assign out_if.lower_mid = out_lower_r;
  assign out_if.upper_mid = out_upper_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> state_r == S_IDLE)
    else $error("pixel input open while sequencer busy");

  a_eof_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_if.end_of_frame |=> state_r == S_LO && div_req.start)
    else $error("end of frame did not start the lower mid division");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_LO || state_r == S_UP || state_r == S_ST)
    else $error("divider finished outside a division phase");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> lo_sum_r == 14'd0 && lo_cnt_r == 8'd0
                         && up_sum_r == 14'd0 && up_cnt_r == 8'd0)
    else $error("accumulators not cleared before result hand-off");
`endif

endmodule

### tb/lane_center_steering_tb.sv
// self-checking testbench for lane_center_steering: drives pixel words, predicts the
// per-frame steering command and checks every command word field by field
// depends on rtl/lcs_pkg.sv, rtl/lcs_if.sv and rtl/lane_center_steering.sv
module lane_center_steering_tb;

  import lcs_pkg::*;

  localparam int unsigned MAX_COLS       = 128;
  localparam int unsigned MAX_ROWS       = 64;
  localparam int unsigned SUM_CAP        = 16383;
  localparam int unsigned CNT_CAP        = 255;
  localparam int unsigned LOST_CAP       = 1023;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned ITEM_TARGET    = 1450;

  typedef enum int {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_STEER_GAIN,
    REG_LOST_LIMIT,
    REG_CRUISE_THROTTLE,
    REG_SEARCH_STEER
  } reg_idx_t;

  typedef struct {
    logic [7:0] pixel;
    logic [6:0] col;
    logic [5:0] row;
    logic       eof;
    bit         drain_first;
  } pix_word_t;

  typedef struct {
    logic signed [15:0] steering;
    logic [14:0]        throttle;
    logic [6:0]         lower_mid;
    logic [6:0]         upper_mid;
  } steer_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lcs_in_if  pix_ch ();
  lcs_out_if cmd_ch ();

  lane_center_steering dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (pix_ch),
    .out_if  (cmd_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copy used by the predictor
  logic [7:0]  r_width;
  logic [6:0]  r_height;
  logic [7:0]  r_gain;
  logic [9:0]  r_lost_limit;
  logic [14:0] r_cruise;
  logic [6:0]  r_search;

  // frame accumulators and tracking state
  int unsigned low_sum, low_cnt, up_sum, up_cnt, lost_cnt;
  bit          heading_up;

  pix_word_t   pix_q[$];
  steer_cmd_t  frame_cmds[$];
  int unsigned mismatches;
  int unsigned items_queued;
  int unsigned idle_cycles;
  bit          pix_taken;
  bit          bursty;
  int unsigned hold_req, hold_ack;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int unsigned cols_in_frame();
    return (r_width > MAX_COLS) ? MAX_COLS : r_width;
  endfunction

  function automatic int unsigned rows_in_frame();
    return (r_height > MAX_ROWS) ? MAX_ROWS : r_height;
  endfunction

  function automatic int unsigned sat_add(input int unsigned sum, input int unsigned col);
    return (sum + col > SUM_CAP) ? SUM_CAP : sum + col;
  endfunction

  function automatic int unsigned lane_mid(input int unsigned sum, input int unsigned cnt);
    if (sum == 0 || cnt == 0) return 0;
    return (sum / cnt > 127) ? 127 : sum / cnt;
  endfunction

  // accumulate one pixel word; on end of frame build the command word
  function automatic bit predict_word(input logic [7:0] pix, input logic [6:0] col,
                                      input logic [5:0] row, input logic eof,
                                      output steer_cmd_t cmd);
    int unsigned wd, ht, lmid, umid, next_lost, hold;
    longint      num, prop;
    int          steer;
    wd = cols_in_frame();
    ht = rows_in_frame();
    cmd = '{default: '0};
    if (pix != 0 && col < wd) begin
      if (row == ht * 3 / 4) begin
        low_sum = sat_add(low_sum, col);
        if (low_cnt < CNT_CAP) low_cnt++;
      end
      if (row == ht / 4) begin
        up_sum = sat_add(up_sum, col);
        if (up_cnt < CNT_CAP) up_cnt++;
      end
    end
    if (!eof) return 1'b0;
    lmid = lane_mid(low_sum, low_cnt);
    umid = lane_mid(up_sum, up_cnt);
    low_sum = 0;
    low_cnt = 0;
    up_sum  = 0;
    up_cnt  = 0;
    prop = 0;
    if (wd != 0) begin
      num  = (2 * longint'(lmid) - longint'(wd)) * longint'(r_gain) * 128;
      prop = num / longint'(wd);
      if (prop > 32767) prop = 32767;
      if (prop < -32768) prop = -32768;
    end
    steer = int'(prop);
    if (lmid != 0 && umid != 0) heading_up = (umid > lmid);
    if (lmid != 0) begin
      lost_cnt = 0;
      cmd.throttle = r_cruise;
    end else begin
      next_lost = lost_cnt + 1;
      if (next_lost > r_lost_limit) begin
        // lost too long: cut throttle, keep the proportional steering of a zero mid
        hold = r_lost_limit + 1;
        lost_cnt = (hold > LOST_CAP) ? LOST_CAP : hold;
        cmd.throttle = '0;
      end else begin
        lost_cnt = next_lost;
        cmd.throttle = r_cruise;
        steer = heading_up ? int'(r_search) * 256 : -(int'(r_search) * 256);
      end
    end
    cmd.steering  = steer[15:0];
    cmd.lower_mid = lmid[6:0];
    cmd.upper_mid = umid[6:0];
    return 1'b1;
  endfunction

  // acceptance tracking, prediction and command word checking
  always @(posedge clk) begin : track
    steer_cmd_t want;
    pix_taken <= rst_n && pix_ch.valid && pix_ch.ready;
    if (rst_n && pix_ch.valid && pix_ch.ready) begin
      if (predict_word(pix_ch.pixel, pix_ch.col, pix_ch.row, pix_ch.end_of_frame, want))
        frame_cmds = {frame_cmds, want};
    end
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      if (frame_cmds.size() == 0) begin
        flag_mismatch("unexpected command word, steering", cmd_ch.steering, 0);
      end else begin
        want = frame_cmds.pop_front();
        if (cmd_ch.steering !== want.steering)
          flag_mismatch("steering", cmd_ch.steering, want.steering);
        if (cmd_ch.throttle !== want.throttle)
          flag_mismatch("throttle", cmd_ch.throttle, want.throttle);
        if (cmd_ch.lower_mid !== want.lower_mid)
          flag_mismatch("lower_mid", cmd_ch.lower_mid, want.lower_mid);
        if (cmd_ch.upper_mid !== want.upper_mid)
          flag_mismatch("upper_mid", cmd_ch.upper_mid, want.upper_mid);
      end
    end
  end

  // pixel word driver
  always @(negedge clk) begin : pix_drive
    int unsigned gap_left;
    if (rst_n) begin
      if (pix_taken) void'(pix_q.pop_front());
      if (!pix_ch.valid || pix_taken) begin
        if (gap_left != 0) begin
          gap_left--;
          pix_ch.valid <= 1'b0;
        end else if (pix_q.size() == 0 ||
                     (pix_q[0].drain_first && frame_cmds.size() != 0)) begin
          pix_ch.valid <= 1'b0;
        end else if (bursty && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 9);
          pix_ch.valid <= 1'b0;
        end else begin
          pix_ch.valid        <= 1'b1;
          pix_ch.pixel        <= pix_q[0].pixel;
          pix_ch.col          <= pix_q[0].col;
          pix_ch.row          <= pix_q[0].row;
          pix_ch.end_of_frame <= pix_q[0].eof;
        end
      end
    end
  end

  // command word receiver, with random stalls and one long hold-off on request
  always @(negedge clk) begin : cmd_drive
    int unsigned hold_left, stall_left;
    if (!rst_n) begin
      cmd_ch.ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = LONG_HOLD;
      cmd_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      cmd_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      cmd_ch.ready <= 1'b0;
    end else if (bursty && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      cmd_ch.ready <= 1'b0;
    end else begin
      cmd_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] got, want;
    case (idx)
      REG_IMAGE_WIDTH:     begin r_width      = val[7:0];  want = r_width;      end
      REG_IMAGE_HEIGHT:    begin r_height     = val[6:0];  want = r_height;     end
      REG_STEER_GAIN:      begin r_gain       = val[7:0];  want = r_gain;       end
      REG_LOST_LIMIT:      begin r_lost_limit = val[9:0];  want = r_lost_limit; end
      REG_CRUISE_THROTTLE: begin r_cruise     = val[14:0]; want = r_cruise;     end
      default:             begin r_search     = val[6:0];  want = r_search;     end
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(int'(idx) * 4);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // read back
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) flag_mismatch("register read back", got, want);
  endtask

  task automatic write_config(input int unsigned w, input int unsigned h, input int unsigned g,
                              input int unsigned l, input int unsigned c, input int unsigned s);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_STEER_GAIN, g);
    write_reg(REG_LOST_LIMIT, l);
    write_reg(REG_CRUISE_THROTTLE, c);
    write_reg(REG_SEARCH_STEER, s);
  endtask

  task automatic write_random_config();
    int unsigned w, h, l;
    case ($urandom_range(0, 9))
      0:       w = $urandom_range(0, 3);
      1:       w = $urandom_range(129, 255);
      default: w = $urandom_range(4, 128);
    endcase
    case ($urandom_range(0, 9))
      0:       h = $urandom_range(0, 3);
      1:       h = $urandom_range(65, 127);
      default: h = $urandom_range(4, 64);
    endcase
    l = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 4) : $urandom_range(0, 1023);
    write_config(w, h, $urandom_range(0, 255), l, $urandom_range(0, 32767),
                 $urandom_range(0, 127));
  endtask

  task automatic push_word(input int unsigned pix, input int unsigned col, input int unsigned row,
                           input bit eof, input bit drain);
    pix_word_t w;
    w.pixel       = pix[7:0];
    w.col         = col[6:0];
    w.row         = row[5:0];
    w.eof         = eof;
    w.drain_first = drain;
    pix_q = {pix_q, w};
    items_queued++;
  endtask

  // many edges on the lower scan row, to push the accumulators into saturation
  task automatic queue_dense_frame(input int unsigned len);
    int unsigned lr;
    lr = rows_in_frame() * 3 / 4;
    for (int unsigned i = 0; i < len; i++)
      push_word($urandom_range(1, 255), $urandom_range(120, 127), lr, i == len - 1, 1'b0);
  endtask

  // a frame of edges clustered around two lane positions, optionally with
  // nothing on the lower scan row; sometimes led by a few random noise words
  task automatic queue_frame(input bit lane_lost, input bit drain);
    int unsigned wd, lr, ur, cl, cu, len, row, pix;
    int          c;
    wd  = cols_in_frame();
    lr  = rows_in_frame() * 3 / 4;
    ur  = rows_in_frame() / 4;
    cl  = (wd != 0) ? $urandom_range(0, wd - 1) : $urandom_range(0, 127);
    cu  = (wd != 0) ? $urandom_range(0, wd - 1) : $urandom_range(0, 127);
    len = $urandom_range(1, 24);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4))
        push_word($urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 63),
                  $urandom_range(0, 5) == 0, drain);
      drain = 1'b0;
    end
    for (int unsigned i = 0; i < len; i++) begin
      pix = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          row = lr;
          c = int'(cl) + int'($urandom_range(0, 6)) - 3;
        end
        4, 5, 6, 7: begin
          row = ur;
          c = int'(cu) + int'($urandom_range(0, 6)) - 3;
        end
        default: begin
          row = $urandom_range(0, 63);
          c = $urandom_range(0, 127);
        end
      endcase
      if (c < 0) c = 0;
      if (c > 127) c = 127;
      if (lane_lost && row == lr) pix = 0;
      push_word(pix, c, row, i == len - 1, drain && i == 0);
    end
  endtask

  task automatic queue_frames(input int unsigned n);
    repeat (n) queue_frame($urandom_range(0, 19) < 7, $urandom_range(0, 7) == 0);
  endtask

  // idle point: all words taken, all commands back, then let the block settle
  task automatic wait_quiet();
    while (pix_q.size() != 0 || frame_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n               = 1'b0;
    pix_ch.valid        = 1'b0;
    pix_ch.pixel        = '0;
    pix_ch.col          = '0;
    pix_ch.row          = '0;
    pix_ch.end_of_frame = 1'b0;
    cmd_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    // register defaults after reset
    r_width      = 80;
    r_height     = 20;
    r_gain       = 50;
    r_lost_limit = 500;
    r_cruise     = 3000;
    r_search     = 40;
    bursty       = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults: width 80, scan rows 15 (lower) and 5 (upper)
    push_word(255, 127, 15, 1'b0, 1'b0);  // column past the width
    push_word(0, 40, 15, 1'b0, 1'b0);     // no edge
    push_word(1, 0, 15, 1'b1, 1'b0);      // lone edge at column 0 reads as no lane
    push_word(128, 60, 15, 1'b0, 1'b0);
    push_word(7, 70, 5, 1'b0, 1'b0);
    push_word(0, 0, 63, 1'b1, 1'b0);      // upper right of lower: heading positive
    push_word(9, 10, 5, 1'b1, 1'b0);      // lost, search to the positive side
    push_word(200, 30, 15, 1'b0, 1'b0);
    push_word(1, 30, 5, 1'b0, 1'b0);
    push_word(0, 127, 0, 1'b1, 1'b0);     // equal mids count as not positive
    push_word(3, 100, 40, 1'b1, 1'b0);    // lost, search to the negative side
    push_word(33, 33, 15, 1'b0, 1'b0);
    push_word(34, 34, 15, 1'b0, 1'b0);
    push_word(255, 79, 15, 1'b1, 1'b0);   // truncating mean
    push_word(85, 85, 42, 1'b0, 1'b0);
    push_word(170, 42, 21, 1'b1, 1'b0);
    wait_quiet();

    // upper extremes, sums saturate
    write_config(255, 127, 255, 0, 32767, 127);
    queue_dense_frame(140);
    queue_frames(8);
    wait_quiet();

    // lower extremes, zero width ignores every pixel
    write_config(0, 0, 0, 0, 0, 0);
    queue_frames(6);
    wait_quiet();

    // height 1: both scan rows on row 0, counts saturate
    write_config(128, 1, 128, 1023, 1, 1);
    queue_dense_frame(270);
    queue_frames(6);
    wait_quiet();

    // first random phase: sender pauses for a drain, receiver holds off long
    write_random_config();
    hold_req++;
    queue_frame(1'b0, 1'b1);
    queue_frames(12);
    wait_quiet();

    while (items_queued < ITEM_TARGET - 80) begin
      write_random_config();
      bursty = ($urandom_range(0, 3) != 0);
      queue_frames(10);
      wait_quiet();
    end

    // closing stretch without idling
    bursty = 1'b0;
    write_random_config();
    queue_frames(7);
    wait_quiet();

    if (frame_cmds.size() != 0) flag_mismatch("commands never returned", frame_cmds.size(), 0);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
